// ===== hdl/tpp_pkg.sv =====
`default_nettype none

package tpp_pkg;

    typedef enum logic [3:0] {
        PH_HDR     = 4'd0,
        PH_ALEN    = 4'd1,
        PH_AFLAGS  = 4'd2,
        PH_PCR     = 4'd3,
        PH_OPCR    = 4'd4,
        PH_SPLICE  = 4'd5,
        PH_PRIVLEN = 4'd6,
        PH_PRIV    = 4'd7,
        PH_ASKIP   = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_DISCARD = 4'd10,
        PH_SUMMARY = 4'd15
    } tpp_phase_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PRIVATE = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [7:0] SYNC_BYTE       = 8'h47;
    localparam logic [7:0] HDR_LAST_POS    = 8'd3;
    localparam logic [8:0] ADAPT_START     = 9'd4;
    localparam logic [7:0] CLOCK_REF_BYTES = 8'd6;

    // adaptation flag byte bit positions
    localparam int AF_PCR_BIT    = 4;
    localparam int AF_OPCR_BIT   = 3;
    localparam int AF_SPLICE_BIT = 2;
    localparam int AF_PRIV_BIT   = 1;

    typedef struct packed {
        logic        valid;
        logic [7:0]  stream_byte;
    } tpp_step_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  item_byte;
        logic [12:0] packet_id;
        logic [5:0]  header_flags;
        logic [1:0]  scrambling;
        logic [3:0]  continuity;
        logic [7:0]  adaptation_flags;
        logic [32:0] pcr_base;
        logic [8:0]  pcr_ext;
        logic [32:0] opcr_base;
        logic [8:0]  opcr_ext;
        logic [7:0]  splice_countdown;
    } tpp_result_t;

    typedef struct packed {
        logic        valid;
        tpp_result_t result;
    } tpp_emit_t;

endpackage

`default_nettype wire

// ===== hdl/tpp_in_if.sv =====
`default_nettype none

interface tpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/tpp_out_if.sv =====
`default_nettype none

interface tpp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         item_kind;
    logic [7:0]         item_byte;
    logic [12:0]        packet_id;
    logic [5:0]         header_flags;
    logic [1:0]         scrambling;
    logic [3:0]         continuity;
    logic [7:0]         adaptation_flags;
    logic [32:0]        pcr_base;
    logic [8:0]         pcr_ext;
    logic [32:0]        opcr_base;
    logic [8:0]         opcr_ext;
    logic signed [7:0]  splice_countdown;

    modport source (
        output valid, output item_kind, output item_byte, output packet_id,
        output header_flags, output scrambling, output continuity,
        output adaptation_flags, output pcr_base, output pcr_ext,
        output opcr_base, output opcr_ext, output splice_countdown,
        input ready
    );
    modport sink (
        input valid, input item_kind, input item_byte, input packet_id,
        input header_flags, input scrambling, input continuity,
        input adaptation_flags, input pcr_base, input pcr_ext,
        input opcr_base, input opcr_ext, input splice_countdown,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/tpp_in_reg.sv =====
`default_nettype none

module tpp_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    tpp_in_if.sink              stream_in,
    input  wire logic           slot_free,
    output tpp_pkg::tpp_step_t  step
);
    import tpp_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign stream_in.ready = !valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stream_in.valid && stream_in.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (slot_free)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream_in.valid && stream_in.ready)
        begin
            byte_reg <= stream_in.stream_byte;
        end
    end

    assign step.valid       = valid_reg;
    assign step.stream_byte = byte_reg;
endmodule

`default_nettype wire

// ===== hdl/tpp_parse.sv =====
`default_nettype none

module tpp_parse #(
    parameter int PAYLOAD_AREA_BYTES = 184
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tpp_pkg::tpp_step_t  step,
    input  wire logic                slot_free,
    output tpp_pkg::tpp_emit_t       emit
);
    import tpp_pkg::*;

    localparam logic [7:0] LAST_POS = 8'(3 + PAYLOAD_AREA_BYTES);

    logic        fire;
    logic [7:0]  b;

    logic [7:0]  byte_position_reg, byte_position_next;
    logic [23:0] header_reg, header_next;
    logic [7:0]  adapt_length_reg, adapt_length_next;
    logic [7:0]  adapt_flag_reg, adapt_flag_next;
    logic [47:0] clock_ref_reg, clock_ref_next;
    logic [41:0] pcr_reg, pcr_next;
    logic [41:0] opcr_reg, opcr_next;
    logic [7:0]  splice_reg, splice_next;
    logic [7:0]  private_left_reg, private_left_next;
    logic        sync_bad_reg, sync_bad_next;
    tpp_phase_t  parse_phase_reg, parse_phase_next;

    tpp_phase_t  nxt;
    logic        has_result;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [8:0]  aend;
    logic [7:0]  left_dec;
    logic [41:0] clock_val;

    // first clock-reference or splice field at or after 'from' whose flag is set
    function automatic tpp_phase_t next_field(input tpp_phase_t from, input logic [7:0] f);
        tpp_phase_t r;
        begin
            if (from <= PH_PCR && f[AF_PCR_BIT])
                r = PH_PCR;
            else if (from <= PH_OPCR && f[AF_OPCR_BIT])
                r = PH_OPCR;
            else if (from <= PH_SPLICE && f[AF_SPLICE_BIT])
                r = PH_SPLICE;
            else
                r = PH_SUMMARY;
            return r;
        end
    endfunction

    assign fire = step.valid && slot_free;
    assign b    = step.stream_byte;

    always_comb
    begin
        header_next       = header_reg;
        adapt_length_next = adapt_length_reg;
        adapt_flag_next   = adapt_flag_reg;
        clock_ref_next    = clock_ref_reg;
        pcr_next          = pcr_reg;
        opcr_next         = opcr_reg;
        splice_next       = splice_reg;
        private_left_next = private_left_reg;
        sync_bad_next     = sync_bad_reg;
        nxt               = parse_phase_reg;
        has_result        = 1'b0;
        kind              = KIND_PAYLOAD;
        data              = 8'h00;
        left_dec          = private_left_reg - {7'd0, (private_left_reg != 8'd0)};
        clock_val         = '0;
        aend              = '0;

        case (parse_phase_reg)
            PH_HDR:
            begin
                if (byte_position_reg == 8'd0)
                begin
                    sync_bad_next     = (b != SYNC_BYTE);
                    header_next       = '0;
                    adapt_length_next = '0;
                    adapt_flag_next   = '0;
                    clock_ref_next    = '0;
                    pcr_next          = '0;
                    opcr_next         = '0;
                    splice_next       = '0;
                    private_left_next = '0;
                end
                else
                begin
                    header_next = {header_reg[15:0], b};
                    if (byte_position_reg >= HDR_LAST_POS)
                    begin
                        if (header_next[5])
                        begin
                            nxt = PH_ALEN;
                        end
                        else
                        begin
                            has_result = 1'b1;
                            kind       = KIND_SUMMARY;
                            nxt        = header_next[4] ? PH_PAYLOAD : PH_DISCARD;
                        end
                    end
                end
            end
            PH_ALEN:
            begin
                adapt_length_next = b;
                nxt               = PH_AFLAGS;
            end
            PH_AFLAGS:
            begin
                adapt_flag_next = b;
                nxt             = next_field(PH_PCR, b);
            end
            PH_PCR, PH_OPCR:
            begin
                clock_ref_next    = {clock_ref_reg[39:0], b};
                private_left_next = left_dec;
                clock_val         = {clock_ref_next[47:15], clock_ref_next[8:0]};
                if (left_dec == 8'd0)
                begin
                    if (parse_phase_reg == PH_PCR)
                    begin
                        pcr_next = clock_val;
                        nxt      = next_field(PH_OPCR, adapt_flag_reg);
                    end
                    else
                    begin
                        opcr_next = clock_val;
                        nxt       = next_field(PH_SPLICE, adapt_flag_reg);
                    end
                end
            end
            PH_SPLICE:
            begin
                splice_next = b;
                nxt         = PH_SUMMARY;
            end
            PH_PRIVLEN:
            begin
                private_left_next = b;
                nxt               = (b != 8'd0) ? PH_PRIV : PH_ASKIP;
            end
            PH_PRIV:
            begin
                has_result        = 1'b1;
                kind              = KIND_PRIVATE;
                data              = b;
                private_left_next = left_dec;
                if (left_dec == 8'd0)
                    nxt = PH_ASKIP;
            end
            PH_PAYLOAD:
            begin
                has_result = 1'b1;
                kind       = KIND_PAYLOAD;
                data       = b;
            end
            default:
            begin
            end
        endcase

        // entering a clock-reference field restarts its byte count
        if (nxt != parse_phase_reg && (nxt == PH_PCR || nxt == PH_OPCR))
        begin
            private_left_next = CLOCK_REF_BYTES;
            clock_ref_next    = '0;
        end

        if (nxt == PH_SUMMARY)
        begin
            has_result = 1'b1;
            kind       = KIND_SUMMARY;
            data       = 8'h00;
            nxt        = adapt_flag_next[AF_PRIV_BIT] ? PH_PRIVLEN : PH_ASKIP;
        end

        // adaptation field end, clipped at the packet end
        if (nxt >= PH_AFLAGS && nxt <= PH_ASKIP)
        begin
            aend = ADAPT_START + {1'b0, adapt_length_next};
            if (aend > {1'b0, LAST_POS})
                aend = {1'b0, LAST_POS};
            if ({1'b0, byte_position_reg} >= aend)
            begin
                if (nxt <= PH_SPLICE)
                begin
                    has_result = 1'b1;
                    kind       = KIND_SUMMARY;
                    data       = 8'h00;
                end
                nxt = (header_next[5:4] == 2'b11) ? PH_PAYLOAD : PH_DISCARD;
            end
        end

        if (byte_position_reg >= LAST_POS)
        begin
            byte_position_next = '0;
            parse_phase_next   = PH_HDR;
        end
        else
        begin
            byte_position_next = byte_position_reg + 8'd1;
            parse_phase_next   = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            header_reg        <= '0;
            adapt_length_reg  <= '0;
            adapt_flag_reg    <= '0;
            clock_ref_reg     <= '0;
            pcr_reg           <= '0;
            opcr_reg          <= '0;
            splice_reg        <= '0;
            private_left_reg  <= '0;
            sync_bad_reg      <= 1'b0;
            parse_phase_reg   <= PH_HDR;
        end
        else if (fire)
        begin
            byte_position_reg <= byte_position_next;
            header_reg        <= header_next;
            adapt_length_reg  <= adapt_length_next;
            adapt_flag_reg    <= adapt_flag_next;
            clock_ref_reg     <= clock_ref_next;
            pcr_reg           <= pcr_next;
            opcr_reg          <= opcr_next;
            splice_reg        <= splice_next;
            private_left_reg  <= private_left_next;
            sync_bad_reg      <= sync_bad_next;
            parse_phase_reg   <= parse_phase_next;
        end
    end

    assign emit.valid                   = fire && has_result;
    assign emit.result.item_kind        = kind;
    assign emit.result.item_byte        = data;
    assign emit.result.packet_id        = header_next[20:8];
    assign emit.result.header_flags     = {sync_bad_next, header_next[5:4], header_next[21],
                                           header_next[22], header_next[23]};
    assign emit.result.scrambling       = header_next[7:6];
    assign emit.result.continuity       = header_next[3:0];
    assign emit.result.adaptation_flags = adapt_flag_next;
    assign emit.result.pcr_base         = pcr_next[41:9];
    assign emit.result.pcr_ext          = pcr_next[8:0];
    assign emit.result.opcr_base        = opcr_next[41:9];
    assign emit.result.opcr_ext         = opcr_next[8:0];
    assign emit.result.splice_countdown = splice_next;

`ifndef NO_ASSERTIONS
    a_pos_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= LAST_POS)
        else $error("byte position beyond packet end");

    a_sync_phase: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg == 8'd0 |-> parse_phase_reg == PH_HDR)
        else $error("packet start outside header phase");

    a_summary_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        parse_phase_reg != PH_SUMMARY)
        else $error("summary phase left in state register");

    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && parse_phase_reg == PH_PAYLOAD |-> emit.valid
            && emit.result.item_kind == KIND_PAYLOAD)
        else $error("payload byte not emitted");
`endif
endmodule

`default_nettype wire

// ===== hdl/tpp_out_reg.sv =====
`default_nettype none

module tpp_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tpp_pkg::tpp_emit_t  emit,
    output logic                     slot_free,
    tpp_out_if.source                result_out
);
    import tpp_pkg::*;

    logic        valid_reg;
    tpp_result_t result_reg;

    assign slot_free = !valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && emit.valid)
        begin
            result_reg <= emit.result;
        end
    end

    assign result_out.valid            = valid_reg;
    assign result_out.item_kind        = result_reg.item_kind;
    assign result_out.item_byte        = result_reg.item_byte;
    assign result_out.packet_id        = result_reg.packet_id;
    assign result_out.header_flags     = result_reg.header_flags;
    assign result_out.scrambling       = result_reg.scrambling;
    assign result_out.continuity       = result_reg.continuity;
    assign result_out.adaptation_flags = result_reg.adaptation_flags;
    assign result_out.pcr_base         = result_reg.pcr_base;
    assign result_out.pcr_ext          = result_reg.pcr_ext;
    assign result_out.opcr_base        = result_reg.opcr_base;
    assign result_out.opcr_ext         = result_reg.opcr_ext;
    assign result_out.splice_countdown = $signed(result_reg.splice_countdown);
endmodule

`default_nettype wire

// ===== hdl/transport_packet_parser.sv =====
// Transport stream packet parser.
// stream_in takes one byte of a packet-aligned stream per transaction; each
// packet is 4 + PAYLOAD_AREA_BYTES bytes starting with the sync byte.
// result_out delivers payload bytes, private data bytes and one header
// summary per packet, every transaction carrying the current packet's
// header, adaptation flags, PCR, OPCR and splice countdown.
// Throughput: one byte per cycle while result_out does not stall. A byte is
// held in the input register; its result, if any, is registered in the
// output register when the parse step takes the byte. The parse step is
// combinational logic between those two registers.
// A byte that produces no result still passes through the parse step.
// Reset clears all parse state; the next byte taken is treated as a sync
// byte. When result_out is stalled with a result held, the parse step waits
// and stream_in takes at most one more byte into the input register.
`default_nettype none

module transport_packet_parser #(
    parameter int PAYLOAD_AREA_BYTES = 184
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tpp_in_if.sink      stream_in,
    tpp_out_if.source   result_out
);
    import tpp_pkg::*;

    tpp_step_t step;
    tpp_emit_t emit;
    logic      slot_free;

    tpp_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream_in (stream_in),
        .slot_free (slot_free),
        .step      (step)
    );

    tpp_parse #(
        .PAYLOAD_AREA_BYTES (PAYLOAD_AREA_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .slot_free (slot_free),
        .emit      (emit)
    );

    tpp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .slot_free  (slot_free),
        .result_out (result_out)
    );
endmodule

`default_nettype wire

// ===== tb/transport_packet_parser_tb.sv =====
module transport_packet_parser_tb;

    import tpp_pkg::*;

    localparam int PAYLOAD_AREA = 184;
    localparam int PKT_BYTES    = 4 + PAYLOAD_AREA;
    localparam int PKT_LAST     = PKT_BYTES - 1;
    localparam int MAX_ALEN     = PKT_LAST - 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 400;
    localparam int REPORT_CAP   = 50;
    localparam int PHASE_BYTES  = 80;
    localparam int TAIL_BYTES   = 24;

    class packet_tracker;
        int              pos;
        bit [23:0]       hdr;
        bit [7:0]        alen;
        bit [7:0]        aflags;
        bit [7:0]        splice;
        bit [7:0]        left;
        bit [47:0]       clk_shift;
        bit [41:0]       pcr;
        bit [41:0]       opcr;
        bit              sync_bad;
        tpp_phase_t      phase;
        tpp_result_t     pending_results[$];
        int              errors;

        function new();
            pos = 0;
            hdr = '0;
            alen = '0;
            aflags = '0;
            splice = '0;
            left = '0;
            clk_shift = '0;
            pcr = '0;
            opcr = '0;
            sync_bad = 1'b0;
            phase = PH_HDR;
            errors = 0;
        endfunction

        function tpp_result_t snapshot(bit [1:0] kind, bit [7:0] data);
            tpp_result_t r;
            r.item_kind        = kind;
            r.item_byte        = data;
            r.packet_id        = hdr[20:8];
            r.header_flags     = {sync_bad, hdr[5:4], hdr[21], hdr[22], hdr[23]};
            r.scrambling       = hdr[7:6];
            r.continuity       = hdr[3:0];
            r.adaptation_flags = aflags;
            r.pcr_base         = pcr[41:9];
            r.pcr_ext          = pcr[8:0];
            r.opcr_base        = opcr[41:9];
            r.opcr_ext         = opcr[8:0];
            r.splice_countdown = splice;
            return r;
        endfunction

        // next clock reference / splice field whose flag is set, at or after 'from'
        function tpp_phase_t first_field(tpp_phase_t from);
            if (from <= PH_PCR && aflags[AF_PCR_BIT])
            begin
                left = CLOCK_REF_BYTES;
                clk_shift = '0;
                return PH_PCR;
            end
            if (from <= PH_OPCR && aflags[AF_OPCR_BIT])
            begin
                left = CLOCK_REF_BYTES;
                clk_shift = '0;
                return PH_OPCR;
            end
            if (from <= PH_SPLICE && aflags[AF_SPLICE_BIT])
                return PH_SPLICE;
            return PH_SUMMARY;
        endfunction

        function void take_byte(bit [7:0] b);
            tpp_phase_t  nxt;
            tpp_result_t r;
            bit          hit;
            int          aend;
            nxt = phase;
            hit = 1'b0;
            case (phase)
                PH_HDR:
                begin
                    if (pos == 0)
                    begin
                        sync_bad = (b != SYNC_BYTE);
                        hdr = '0;
                        alen = '0;
                        aflags = '0;
                        clk_shift = '0;
                        pcr = '0;
                        opcr = '0;
                        splice = '0;
                        left = '0;
                    end
                    else
                    begin
                        hdr = {hdr[15:0], b};
                        if (pos >= int'(HDR_LAST_POS))
                        begin
                            if (hdr[5:4] >= 2'd2)
                                nxt = PH_ALEN;
                            else
                            begin
                                r = snapshot(KIND_SUMMARY, 8'h00);
                                hit = 1'b1;
                                nxt = (hdr[5:4] == 2'd1) ? PH_PAYLOAD : PH_DISCARD;
                            end
                        end
                    end
                end
                PH_ALEN:
                begin
                    alen = b;
                    nxt = PH_AFLAGS;
                end
                PH_AFLAGS:
                begin
                    aflags = b;
                    nxt = first_field(PH_PCR);
                end
                PH_PCR, PH_OPCR:
                begin
                    clk_shift = {clk_shift[39:0], b};
                    if (left > 0)
                        left--;
                    if (left == 0)
                    begin
                        if (phase == PH_PCR)
                        begin
                            pcr = {clk_shift[47:15], clk_shift[8:0]};
                            nxt = first_field(PH_OPCR);
                        end
                        else
                        begin
                            opcr = {clk_shift[47:15], clk_shift[8:0]};
                            nxt = first_field(PH_SPLICE);
                        end
                    end
                end
                PH_SPLICE:
                begin
                    splice = b;
                    nxt = PH_SUMMARY;
                end
                PH_PRIVLEN:
                begin
                    left = b;
                    nxt = (b != 8'h00) ? PH_PRIV : PH_ASKIP;
                end
                PH_PRIV:
                begin
                    r = snapshot(KIND_PRIVATE, b);
                    hit = 1'b1;
                    if (left > 0)
                        left--;
                    if (left == 0)
                        nxt = PH_ASKIP;
                end
                PH_PAYLOAD:
                begin
                    r = snapshot(KIND_PAYLOAD, b);
                    hit = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (nxt == PH_SUMMARY)
            begin
                r = snapshot(KIND_SUMMARY, 8'h00);
                hit = 1'b1;
                nxt = aflags[AF_PRIV_BIT] ? PH_PRIVLEN : PH_ASKIP;
            end

            // end of adaptation field, clamped to the packet end
            if (nxt >= PH_AFLAGS && nxt <= PH_ASKIP)
            begin
                aend = int'(ADAPT_START) + int'(alen);
                if (aend > PKT_LAST)
                    aend = PKT_LAST;
                if (pos >= aend)
                begin
                    if (nxt <= PH_SPLICE)
                    begin
                        r = snapshot(KIND_SUMMARY, 8'h00);
                        hit = 1'b1;
                    end
                    nxt = (hdr[5:4] == 2'd3) ? PH_PAYLOAD : PH_DISCARD;
                end
            end

            if (pos >= PKT_LAST)
            begin
                pos = 0;
                phase = PH_HDR;
            end
            else
            begin
                pos++;
                phase = nxt;
            end

            if (hit)
                pending_results.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < REPORT_CAP)
                $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
            errors++;
        endtask

        task match_result(tpp_result_t got);
            tpp_result_t want;
            if (pending_results.size() == 0)
            begin
                report("transaction with nothing expected, kind", 64'(got.item_kind), 64'(0));
                return;
            end
            want = pending_results.pop_front();
            if (got.item_kind !== want.item_kind)
                report("item_kind", 64'(got.item_kind), 64'(want.item_kind));
            if (got.item_byte !== want.item_byte)
                report("item_byte", 64'(got.item_byte), 64'(want.item_byte));
            if (got.packet_id !== want.packet_id)
                report("packet_id", 64'(got.packet_id), 64'(want.packet_id));
            if (got.header_flags !== want.header_flags)
                report("header_flags", 64'(got.header_flags), 64'(want.header_flags));
            if (got.scrambling !== want.scrambling)
                report("scrambling", 64'(got.scrambling), 64'(want.scrambling));
            if (got.continuity !== want.continuity)
                report("continuity", 64'(got.continuity), 64'(want.continuity));
            if (got.adaptation_flags !== want.adaptation_flags)
                report("adaptation_flags", 64'(got.adaptation_flags),
                       64'(want.adaptation_flags));
            if (got.pcr_base !== want.pcr_base)
                report("pcr_base", 64'(got.pcr_base), 64'(want.pcr_base));
            if (got.pcr_ext !== want.pcr_ext)
                report("pcr_ext", 64'(got.pcr_ext), 64'(want.pcr_ext));
            if (got.opcr_base !== want.opcr_base)
                report("opcr_base", 64'(got.opcr_base), 64'(want.opcr_base));
            if (got.opcr_ext !== want.opcr_ext)
                report("opcr_ext", 64'(got.opcr_ext), 64'(want.opcr_ext));
            if (got.splice_countdown !== want.splice_countdown)
                report("splice_countdown", 64'(got.splice_countdown),
                       64'(want.splice_countdown));
        endtask

        task finish_check();
            if (pending_results.size() != 0)
                report("results never delivered, count", 64'(pending_results.size()), 64'(0));
        endtask
    endclass

    typedef struct {
        bit [7:0]  sync;
        bit        tei;
        bit        pusi;
        bit        prio;
        bit [12:0] pid;
        bit [1:0]  scr;
        bit [1:0]  ctrl;
        bit [3:0]  cc;
        bit        alen_auto;
        bit [7:0]  alen;
        bit [7:0]  aflags;
        bit [7:0]  splice;
        bit [7:0]  priv_len;
        int        stuffing;
        int        fill;
    } pkt_spec_t;

    logic clk;
    logic rst_n;

    tpp_in_if  stream_in_if ();
    tpp_out_if result_out_if ();

    transport_packet_parser #(
        .PAYLOAD_AREA_BYTES(PAYLOAD_AREA)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream_in  (stream_in_if),
        .result_out (result_out_if)
    );

    packet_tracker tracker;
    bit [7:0]      pkt [PKT_BYTES];
    int            gap_pct;
    int            stall_pct;
    int            hold_left;
    int            cycles;
    int            sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pkt_spec_t base_spec();
        pkt_spec_t s;
        s.sync = SYNC_BYTE;
        s.tei = 1'b0;
        s.pusi = 1'b0;
        s.prio = 1'b0;
        s.pid = '0;
        s.scr = '0;
        s.ctrl = 2'd1;
        s.cc = '0;
        s.alen_auto = 1'b1;
        s.alen = '0;
        s.aflags = '0;
        s.splice = '0;
        s.priv_len = '0;
        s.stuffing = 0;
        s.fill = -1;
        return s;
    endfunction

    function automatic pkt_spec_t random_spec();
        pkt_spec_t s;
        int        pick;
        s = base_spec();
        if ($urandom_range(9) == 0)
            s.sync = 8'($urandom);
        {s.tei, s.pusi, s.prio} = 3'($urandom);
        s.pid = 13'($urandom);
        s.scr = 2'($urandom);
        s.cc = 4'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            s.ctrl = 2'd0;
        else if (pick < 40)
            s.ctrl = 2'd1;
        else if (pick < 60)
            s.ctrl = 2'd2;
        else
            s.ctrl = 2'd3;
        s.alen_auto = ($urandom_range(4) != 0);
        s.alen = 8'($urandom);
        s.aflags = 8'($urandom);
        s.splice = 8'($urandom);
        s.priv_len = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        s.stuffing = ($urandom_range(3) == 0) ? $urandom_range(150) : $urandom_range(4);
        return s;
    endfunction

    function automatic void build_packet(pkt_spec_t s);
        int i;
        int p;
        int need;
        for (i = 0; i < PKT_BYTES; i++)
            pkt[i] = (s.fill < 0) ? 8'($urandom) : 8'(s.fill);
        pkt[0] = s.sync;
        pkt[1] = {s.tei, s.pusi, s.prio, s.pid[12:8]};
        pkt[2] = s.pid[7:0];
        pkt[3] = {s.scr, s.ctrl, s.cc};
        if (s.ctrl >= 2'd2)
        begin
            need = 1 + (s.aflags[AF_PCR_BIT] ? 6 : 0) + (s.aflags[AF_OPCR_BIT] ? 6 : 0)
                 + (s.aflags[AF_SPLICE_BIT] ? 1 : 0)
                 + (s.aflags[AF_PRIV_BIT] ? 1 + int'(s.priv_len) : 0) + s.stuffing;
            if (need > MAX_ALEN)
                need = MAX_ALEN;
            pkt[4] = s.alen_auto ? 8'(need) : s.alen;
            pkt[5] = s.aflags;
            p = 6 + (s.aflags[AF_PCR_BIT] ? 6 : 0) + (s.aflags[AF_OPCR_BIT] ? 6 : 0);
            if (s.aflags[AF_SPLICE_BIT])
            begin
                pkt[p] = s.splice;
                p++;
            end
            if (s.aflags[AF_PRIV_BIT])
                pkt[p] = s.priv_len;
        end
    endfunction

    // idling phases are switched by the count of transactions sent
    task automatic send_byte(input bit [7:0] b);
        if (sent == PHASE_BYTES)
        begin
            hold_left = LONG_HOLD;
        end
        else if (sent == 2 * PHASE_BYTES)
        begin
            gap_pct = 66;
        end
        else if (sent == 3 * PHASE_BYTES)
        begin
            gap_pct = 0;
            stall_pct = 66;
        end
        else if (sent == 4 * PHASE_BYTES)
        begin
            gap_pct = 36;
            stall_pct = 36;
        end
        while (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            stream_in_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_in_if.valid <= 1'b1;
        stream_in_if.stream_byte <= b;
        do
            @(posedge clk);
        while (stream_in_if.ready !== 1'b1);
        tracker.take_byte(b);
        sent++;
    endtask

    task automatic send_packet(input pkt_spec_t s, input int count);
        int i;
        build_packet(s);
        for (i = 0; i < count; i++)
            send_byte(pkt[i]);
    endtask

    task automatic stimulus();
        pkt_spec_t s;
        // every parsed field, stuffing, then payload
        s = base_spec();
        s.ctrl = 2'd3;
        s.pusi = 1'b1;
        s.pid = 13'h1FFF;
        s.aflags = 8'h1E;
        s.priv_len = 8'd5;
        s.stuffing = 3;
        s.splice = 8'h80;
        send_packet(s, PKT_BYTES);
        s = random_spec();
        send_packet(s, PKT_BYTES);
        // PCR cut short, near-miss sync; only the start of the packet is sent
        s = base_spec();
        s.ctrl = 2'd2;
        s.sync = 8'h46;
        s.alen_auto = 1'b0;
        s.alen = 8'd4;
        s.aflags = 8'h10;
        send_packet(s, TAIL_BYTES);
    endtask

    function automatic tpp_result_t sample_result();
        tpp_result_t r;
        r.item_kind        = result_out_if.item_kind;
        r.item_byte        = result_out_if.item_byte;
        r.packet_id        = result_out_if.packet_id;
        r.header_flags     = result_out_if.header_flags;
        r.scrambling       = result_out_if.scrambling;
        r.continuity       = result_out_if.continuity;
        r.adaptation_flags = result_out_if.adaptation_flags;
        r.pcr_base         = result_out_if.pcr_base;
        r.pcr_ext          = result_out_if.pcr_ext;
        r.opcr_base        = result_out_if.opcr_base;
        r.opcr_ext         = result_out_if.opcr_ext;
        r.splice_countdown = result_out_if.splice_countdown;
        return r;
    endfunction

    // result side: random stalls plus an optional long hold-off
    initial
    begin
        result_out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_out_if.valid === 1'b1 && result_out_if.ready === 1'b1)
                tracker.match_result(sample_result());
            if (hold_left > 0)
            begin
                hold_left--;
                result_out_if.ready <= 1'b0;
            end
            else
                result_out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("transport_packet_parser: mismatch");
        $finish;
    end

    initial
    begin
        tracker = new();
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        sent = 0;
        rst_n <= 1'b0;
        stream_in_if.valid <= 1'b0;
        stream_in_if.stream_byte <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stimulus();

        stream_in_if.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.finish_check();
        if (tracker.errors == 0)
            $display("transport_packet_parser: match");
        else
            $display("transport_packet_parser: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tpp_pkg.sv
hdl/tpp_in_if.sv
hdl/tpp_out_if.sv
hdl/tpp_in_reg.sv
hdl/tpp_parse.sv
hdl/tpp_out_reg.sv
hdl/transport_packet_parser.sv
tb/transport_packet_parser_tb.sv
